>>> sv/sm4_pkg.sv
// Shared types, constants and table functions for the SM4 cipher core.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sm4_pkg;

  localparam int WORD_W = 32;
  localparam int RK_DEPTH = 32;
  localparam int RK_AW = 5;
  localparam int CFG_IW = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RK_AW-1:0] rk_addr_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_KEY_WORD_0 = 2'd0,
    CFG_KEY_WORD_1 = 2'd1,
    CFG_KEY_WORD_2 = 2'd2,
    CFG_KEY_WORD_3 = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_t;

  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // CK byte j of word i is (4i + j) * 7 mod 256, byte 0 in the top position.
  function automatic word_t ck_word(input rk_addr_t i);
    logic [7:0] base;
    logic [7:0] b;
    word_t r;
    base = {1'b0, i, 2'b00};
    r = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'((base + 8'(j)) * 8'd7);
      r[8*(3-j) +: 8] = b;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/sm4_rk_mem.sv
// Round key memory: 32 x 32 bits, one write port, one registered read port.
// Depends on sm4_pkg for word and address types.
`default_nettype none

module sm4_rk_mem import sm4_pkg::*; (
  input  wire      clk,
  input  wire      wr_en,
  input  rk_addr_t wr_addr,
  input  word_t    wr_data,
  input  rk_addr_t rd_addr,
  output word_t    rd_data
);

  word_t mem_r [RK_DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/sm4_tunit.sv
// SM4 nonlinear transform shared by key expansion and the data rounds.
// Byte-wise S-box followed by the key or data linear mix; uses sm4_pkg.
`default_nettype none

module sm4_tunit import sm4_pkg::*; (
  input  word_t a,
  input  wire   key_mode,
  output word_t t
);

  word_t c;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c[8*k +: 8] = sbox(a[8*k +: 8]);
    end
  end

  assign t = key_mode
           ? (c ^ {c[18:0], c[31:19]} ^ {c[8:0], c[31:9]})
           : (c ^ {c[29:0], c[31:30]} ^ {c[21:0], c[31:22]}
                ^ {c[13:0], c[31:14]} ^ {c[7:0], c[31:8]});

endmodule

`default_nettype wire

>>> sv/sm4_block_cipher_top.sv
// SM4 block cipher core, one 128-bit block per item, in_kind 0 encrypts and 1 decrypts.
// Depends on sm4_pkg, sm4_rk_mem and sm4_tunit.
`default_nettype none

// One round per cycle through a single transform unit; the round key for the
// next round is read from the registered round key memory in the cycle before
// that round runs. With expanded keys an accepted item passes through the load,
// round and finish states, and the result moves into the output register in
// the finish state. The first item after reset or after any key register write
// first expands the round keys. A new item is accepted once the previous one
// has been moved into the output register, which holds it until taken. Key
// registers are to be written only while idle; the core does not enforce this.
module sm4_block_cipher_top import sm4_pkg::*; #(
  parameter int ROUND_COUNT = 32
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      cfg_we,
  input  cfg_idx_t cfg_index,
  input  word_t    cfg_wdata,
  input  wire      in_valid,
  output logic     in_ready,
  input  wire      in_kind,
  input  word_t    in_word_0,
  input  word_t    in_word_1,
  input  word_t    in_word_2,
  input  word_t    in_word_3,
  output logic     out_valid,
  input  wire      out_ready,
  output word_t    out_word_0,
  output word_t    out_word_1,
  output word_t    out_word_2,
  output word_t    out_word_3
);

  localparam int CW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(ROUND_COUNT - 1);
  localparam rk_addr_t KI_LAST = RK_AW'(ROUND_COUNT - 1);

  ctrl_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic keys_valid_r, keys_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic kind_r;
  word_t key_r [4];
  word_t k_r [4];
  word_t x_r [4];
  word_t out_r [4];

  logic  accept, k_shift, x_shift, out_load, expand_done;
  word_t t_in, t_out, rk_rdata, nx_key, nx_data;
  rk_addr_t rk_raddr;

  // Round key index for a given round, reversed for decryption.
  function automatic rk_addr_t key_index(input logic kind, input logic [CW-1:0] c);
    return kind ? rk_addr_t'(KI_LAST - RK_AW'(c)) : RK_AW'(c);
  endfunction

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    k_shift     = 1'b0;
    x_shift     = 1'b0;
    out_load    = 1'b0;
    expand_done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt   = '0;
          state_nxt = keys_valid_r ? ST_LOAD : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        k_shift = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt     = '0;
          expand_done = 1'b1;
          state_nxt   = ST_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        x_shift = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    keys_valid_nxt = keys_valid_r;
    if (cfg_we) begin
      keys_valid_nxt = 1'b0;
    end else if (expand_done) begin
      keys_valid_nxt = 1'b1;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      keys_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      keys_valid_r <= keys_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_WORD_0: key_r[0] <= cfg_wdata;
        CFG_KEY_WORD_1: key_r[1] <= cfg_wdata;
        CFG_KEY_WORD_2: key_r[2] <= cfg_wdata;
        CFG_KEY_WORD_3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The transform unit serves key expansion or a data round, never both at once.
  assign t_in = (state_r == ST_EXPAND)
              ? (k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_word(RK_AW'(cnt_r)))
              : (x_r[1] ^ x_r[2] ^ x_r[3] ^ rk_rdata);
  assign nx_key  = k_r[0] ^ t_out;
  assign nx_data = x_r[0] ^ t_out;

  sm4_tunit u_tunit (
    .a        (t_in),
    .key_mode (state_r == ST_EXPAND),
    .t        (t_out)
  );

  // The read address follows the next round, so its key is ready when that round runs.
  assign rk_raddr = key_index(kind_r, cnt_nxt);

  sm4_rk_mem u_rk_mem (
    .clk     (clk),
    .wr_en   (k_shift),
    .wr_addr (RK_AW'(cnt_r)),
    .wr_data (nx_key),
    .rd_addr (rk_raddr),
    .rd_data (rk_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      x_r[0] <= in_word_0;
      x_r[1] <= in_word_1;
      x_r[2] <= in_word_2;
      x_r[3] <= in_word_3;
      for (int i = 0; i < 4; i++) begin
        k_r[i] <= key_r[i] ^ FK[i];
      end
    end else begin
      if (k_shift) begin
        k_r[0] <= k_r[1];
        k_r[1] <= k_r[2];
        k_r[2] <= k_r[3];
        k_r[3] <= nx_key;
      end
      if (x_shift) begin
        x_r[0] <= x_r[1];
        x_r[1] <= x_r[2];
        x_r[2] <= x_r[3];
        x_r[3] <= nx_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r[0] <= x_r[3];
      out_r[1] <= x_r[2];
      out_r[2] <= x_r[1];
      out_r[3] <= x_r[0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word_0 = out_r[0];
  assign out_word_1 = out_r[1];
  assign out_word_2 = out_r[2];
  assign out_word_3 = out_r[3];

endmodule

`default_nettype wire
